// File: design/ptl_pkg.sv
// Package: shared types and constants of the pedestrian traffic light controller.
package ptl_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CountWidth = 4;
  localparam int unsigned IdxWidth   = 3;

  typedef enum logic [2:0] {
    PH_YELLOW    = 3'd0,
    PH_RED       = 3'd1,
    PH_WALK      = 3'd2,
    PH_BLINK_ON  = 3'd3,
    PH_BLINK_OFF = 3'd4,
    PH_GREEN     = 3'd5
  } ptl_phase_e;

  typedef enum logic [IdxWidth-1:0] {
    REG_RED_WAIT    = 3'd0,
    REG_GREEN_MIN   = 3'd1,
    REG_WALK_TIME   = 3'd2,
    REG_BLINK_HALF  = 3'd3,
    REG_BLINK_COUNT = 3'd4
  } ptl_reg_e;

  localparam logic [CfgWidth-1:0]   RedWaitRst    = 16'd2000;
  localparam logic [CfgWidth-1:0]   GreenMinRst   = 16'd3000;
  localparam logic [CfgWidth-1:0]   WalkTimeRst   = 16'd5000;
  localparam logic [CfgWidth-1:0]   BlinkHalfRst  = 16'd500;
  localparam logic [CountWidth-1:0] BlinkCountRst = 4'd5;

  typedef struct packed {
    logic [CfgWidth-1:0]   red_wait;
    logic [CfgWidth-1:0]   green_min;
    logic [CfgWidth-1:0]   walk_time;
    logic [CfgWidth-1:0]   blink_half;
    logic [CountWidth-1:0] blink_count;
  } ptl_cfg_t;

  typedef struct packed {
    logic car_red;
    logic car_yellow;
    logic car_green;
    logic walk_red;
    logic walk_green;
  } ptl_lamps_t;

endpackage

// File: design/ptl_in_if.sv
// Interface: tick channel carrying the sampled pedestrian button.
interface ptl_in_if;
  logic valid;
  logic ready;
  logic button;

  modport source (output valid, output button, input ready);
  modport sink   (input valid, input button, output ready);
endinterface

// File: design/ptl_out_if.sv
// Interface: result channel carrying the lamp states.
interface ptl_out_if;
  logic valid;
  logic ready;
  logic car_red;
  logic car_yellow;
  logic car_green;
  logic walk_red;
  logic walk_green;

  modport source (output valid, output car_red, output car_yellow, output car_green,
                  output walk_red, output walk_green, input ready);
  modport sink   (input valid, input car_red, input car_yellow, input car_green,
                  input walk_red, input walk_green, output ready);
endinterface

// File: design/pedestrian_traffic_light_controller.sv
// Top level: pedestrian crossing traffic light controller, one tick per transfer.
// A result is registered: the input register is loaded at the tick transfer, and
//   the result register is loaded with the phase state when that tick advances.
// Throughput: one tick per cycle unless stalled; one logic pass per phase update.
// Reset: asynchronous, active low; car yellow phase, timer and request cleared,
//   registers back to their defaults; no clearing pass.
module pedestrian_traffic_light_controller
  import ptl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ptl_in_if.sink              in_i,
  ptl_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i
);

  ptl_cfg_t   cfg;
  ptl_lamps_t lamps_d, lamps_q;
  logic       in_valid_d, in_valid_q;
  logic       out_valid_d, out_valid_q;
  logic       button_q;
  logic       advance;

  ptl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ptl_fsm #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .button_i (button_q),
    .cfg_i    (cfg),
    .lamps_o  (lamps_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign in_valid_d  = (in_i.valid && in_i.ready) || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      button_q <= in_i.button;
    end
    if (advance) begin
      lamps_q <= lamps_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.car_red    = lamps_q.car_red;
  assign out_o.car_yellow = lamps_q.car_yellow;
  assign out_o.car_green  = lamps_q.car_green;
  assign out_o.walk_red   = lamps_q.walk_red;
  assign out_o.walk_green = lamps_q.walk_green;

`ifndef SYNTHESIS
  a_car_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({lamps_q.car_red, lamps_q.car_yellow, lamps_q.car_green}))
    else $error("car lamps not one-hot");

  a_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(lamps_q.walk_red && lamps_q.walk_green))
    else $error("both pedestrian lamps on");

  a_walk_needs_red: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && lamps_q.walk_green) |-> lamps_q.car_red)
    else $error("pedestrian green without car red");

  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result without a tick");

  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending tick lost");
`endif

endmodule

// File: design/ptl_cfg_regs.sv
// Configuration register file: timing thresholds and blink count.
module ptl_cfg_regs
  import ptl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [IdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0] cfg_data_i,
  output ptl_cfg_t            cfg_o
);

  ptl_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (ptl_reg_e'(cfg_idx_i))
        REG_RED_WAIT:    cfg_d.red_wait    = cfg_data_i;
        REG_GREEN_MIN:   cfg_d.green_min   = cfg_data_i;
        REG_WALK_TIME:   cfg_d.walk_time   = cfg_data_i;
        REG_BLINK_HALF:  cfg_d.blink_half  = cfg_data_i;
        REG_BLINK_COUNT: cfg_d.blink_count = cfg_data_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_wait    <= RedWaitRst;
      cfg_q.green_min   <= GreenMinRst;
      cfg_q.walk_time   <= WalkTimeRst;
      cfg_q.blink_half  <= BlinkHalfRst;
      cfg_q.blink_count <= BlinkCountRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/ptl_fsm.sv
// Phase state machine: elapsed timer, request latch, blink counter and lamp decode.
module ptl_fsm
  import ptl_pkg::*;
#(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       button_i,
  input  ptl_cfg_t   cfg_i,
  output ptl_lamps_t lamps_o
);

  localparam int unsigned CmpWidth = (TIMER_WIDTH > CfgWidth) ? TIMER_WIDTH : CfgWidth;

  ptl_phase_e              phase_d, phase_q;
  logic [TIMER_WIDTH-1:0]  elapsed_d, elapsed_q, elapsed_inc;
  logic                    request_d, request_q, request_lat;
  logic [CountWidth-1:0]   blinks_d, blinks_q, blinks_inc;
  logic [CmpWidth-1:0]     el_ext;
  logic                    in_crossing;

  assign in_crossing = (phase_q == PH_WALK) || (phase_q == PH_BLINK_ON) ||
                       (phase_q == PH_BLINK_OFF);
  assign request_lat = request_q | (button_i & ~in_crossing);
  assign elapsed_inc = (elapsed_q == {TIMER_WIDTH{1'b1}}) ? elapsed_q
                                                          : elapsed_q + 1'b1;
  assign el_ext      = CmpWidth'(elapsed_inc);
  assign blinks_inc  = blinks_q + 1'b1;

  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_inc;
    request_d = request_lat;
    blinks_d  = blinks_q;
    case (phase_q)
      PH_YELLOW: begin
        if (el_ext > CmpWidth'(cfg_i.red_wait)) begin
          phase_d   = request_lat ? PH_WALK : PH_RED;
          elapsed_d = '0;
        end
      end
      PH_WALK: begin
        if (el_ext >= CmpWidth'(cfg_i.walk_time)) begin
          blinks_d  = '0;
          elapsed_d = '0;
          if (cfg_i.blink_count == '0) begin
            request_d = 1'b0;
            phase_d   = PH_RED;
          end else begin
            phase_d = PH_BLINK_ON;
          end
        end
      end
      PH_BLINK_ON: begin
        if (el_ext >= CmpWidth'(cfg_i.blink_half)) begin
          phase_d   = PH_BLINK_OFF;
          elapsed_d = '0;
        end
      end
      PH_BLINK_OFF: begin
        if (el_ext >= CmpWidth'(cfg_i.blink_half)) begin
          blinks_d  = blinks_inc;
          elapsed_d = '0;
          if (blinks_inc >= cfg_i.blink_count) begin
            request_d = 1'b0;
            phase_d   = PH_RED;
          end else begin
            phase_d = PH_BLINK_ON;
          end
        end
      end
      PH_RED: begin
        // pending request skips green entirely
        if (el_ext > CmpWidth'(cfg_i.green_min)) begin
          phase_d   = request_lat ? PH_YELLOW : PH_GREEN;
          elapsed_d = '0;
        end
      end
      PH_GREEN: begin
        if (request_lat) begin
          phase_d   = PH_YELLOW;
          elapsed_d = '0;
        end
      end
      default: begin
        phase_d   = PH_YELLOW;
        elapsed_d = '0;
      end
    endcase

    lamps_o.car_yellow = (phase_d == PH_YELLOW);
    lamps_o.car_green  = (phase_d == PH_GREEN);
    lamps_o.car_red    = !lamps_o.car_yellow && !lamps_o.car_green;
    lamps_o.walk_green = (phase_d == PH_WALK) || (phase_d == PH_BLINK_ON);
    lamps_o.walk_red   = (phase_d == PH_YELLOW) || (phase_d == PH_RED) ||
                         (phase_d == PH_GREEN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_YELLOW;
      elapsed_q <= '0;
      request_q <= 1'b0;
      blinks_q  <= '0;
    end else if (en_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      request_q <= request_d;
      blinks_q  <= blinks_d;
    end
  end

endmodule
